>>> rtl/core/mts_pkg.sv
// Package for the min-tracking stack: widths, codes and state type.
package mts_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned DEPTH_W         = 11;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned STATUS_W        = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP_RD
  } state_t;

endpackage

>>> rtl/core/min_tracking_stack.sv
// Min-tracking LIFO stack: value and minima memories with cached tops.
// Push, peek, unused-kind and refused operations: result strobe the cycle after start.
// Pop: goes through ST_POP_RD, which loads the new tops read synchronously from memory.
// busy is high during the pop read cycle; a new start is taken in the strobe cycle.
// Reset: synchronous active-low rst_n clears both counts and control; memories
// are not cleared and need no clearing pass. Results cannot be stalled.
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mts_pkg::KIND_W-1:0]           in_kind,
  input  logic signed [mts_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_valid,
  output logic signed [mts_pkg::DATA_W-1:0]    out_top_value,
  output logic signed [mts_pkg::DATA_W-1:0]    out_min_value,
  output logic [mts_pkg::DEPTH_W-1:0]          out_depth,
  output logic                                 out_is_empty,
  output logic [mts_pkg::STATUS_W-1:0]         out_status
);

  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic signed [mts_pkg::DATA_W-1:0] value_mem  [STACK_DEPTH];
  logic signed [mts_pkg::DATA_W-1:0] minima_mem [STACK_DEPTH];

  mts_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]                  vcnt_r, vcnt_nxt;
  logic [CNT_W-1:0]                  mcnt_r, mcnt_nxt;
  logic signed [mts_pkg::DATA_W-1:0] top_r, top_nxt;
  logic signed [mts_pkg::DATA_W-1:0] min_r, min_nxt;
  logic                              pend_min_r, pend_min_nxt;
  logic                              strobe_r, strobe_nxt;
  mts_pkg::status_t                  status_r, status_nxt;

  logic signed [mts_pkg::DATA_W-1:0] vrd_r;
  logic signed [mts_pkg::DATA_W-1:0] mrd_r;

  logic             accept;
  mts_pkg::kind_t   kind;
  logic             push_ok;
  logic             push_min;
  logic             pop_ok;
  logic             pop_min;
  logic [CNT_W-1:0] vrd_cnt;
  logic [CNT_W-1:0] mrd_cnt;
  logic [CNT_W+mts_pkg::DEPTH_W-1:0] depth_ext;

  assign accept  = start && !busy;
  assign kind    = mts_pkg::kind_t'(in_kind);
  assign push_ok = accept && (kind == mts_pkg::KIND_PUSH) && (vcnt_r < CNT_MAX);
  assign push_min = push_ok && (mcnt_r < CNT_MAX) &&
                    ((mcnt_r == '0) || (in_value <= min_r));
  assign pop_ok  = accept && (kind == mts_pkg::KIND_POP) && (vcnt_r != '0);
  assign pop_min = (mcnt_r != '0) && (top_r <= min_r);
  assign vrd_cnt = vcnt_r - CNT_TWO;
  assign mrd_cnt = mcnt_r - CNT_TWO;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mts_pkg::ST_IDLE: begin
        if (pop_ok) begin
          state_nxt = mts_pkg::ST_POP_RD;
        end
      end
      mts_pkg::ST_POP_RD: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    vcnt_nxt     = vcnt_r;
    mcnt_nxt     = mcnt_r;
    top_nxt      = top_r;
    min_nxt      = min_r;
    pend_min_nxt = pend_min_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    busy         = 1'b0;
    unique case (state_r)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          status_nxt = mts_pkg::STATUS_OK;
          case (kind)
            mts_pkg::KIND_PUSH: begin
              if (push_ok) begin
                vcnt_nxt = vcnt_r + CNT_ONE;
                top_nxt  = in_value;
                if (push_min) begin
                  mcnt_nxt = mcnt_r + CNT_ONE;
                  min_nxt  = in_value;
                end
                strobe_nxt = 1'b1;
              end else begin
                status_nxt = mts_pkg::STATUS_FULL;
                strobe_nxt = 1'b1;
              end
            end
            mts_pkg::KIND_POP: begin
              if (pop_ok) begin
                vcnt_nxt     = vcnt_r - CNT_ONE;
                mcnt_nxt     = pop_min ? (mcnt_r - CNT_ONE) : mcnt_r;
                pend_min_nxt = pop_min;
              end else begin
                status_nxt = mts_pkg::STATUS_EMPTY;
                strobe_nxt = 1'b1;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      mts_pkg::ST_POP_RD: begin
        busy       = 1'b1;
        top_nxt    = vrd_r;
        if (pend_min_r) begin
          min_nxt = mrd_r;
        end
        strobe_nxt = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mts_pkg::ST_IDLE;
      vcnt_r     <= '0;
      mcnt_r     <= '0;
      pend_min_r <= 1'b0;
      strobe_r   <= 1'b0;
      status_r   <= mts_pkg::STATUS_OK;
    end else begin
      state_r    <= state_nxt;
      vcnt_r     <= vcnt_nxt;
      mcnt_r     <= mcnt_nxt;
      pend_min_r <= pend_min_nxt;
      strobe_r   <= strobe_nxt;
      status_r   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    min_r <= min_nxt;
  end

  // value memory: write on push, read new top on pop
  always_ff @(posedge clk) begin
    if (push_ok) begin
      value_mem[vcnt_r[AW-1:0]] <= in_value;
    end
    vrd_r <= value_mem[vrd_cnt[AW-1:0]];
  end

  // minima memory
  always_ff @(posedge clk) begin
    if (push_min) begin
      minima_mem[mcnt_r[AW-1:0]] <= in_value;
    end
    mrd_r <= minima_mem[mrd_cnt[AW-1:0]];
  end

  assign depth_ext     = {{mts_pkg::DEPTH_W{1'b0}}, vcnt_r};
  assign out_valid     = strobe_r;
  assign out_top_value = (vcnt_r != '0) ? top_r : '0;
  assign out_min_value = ((vcnt_r != '0) && (mcnt_r != '0)) ? min_r : '0;
  assign out_depth     = depth_ext[mts_pkg::DEPTH_W-1:0];
  assign out_is_empty  = (vcnt_r == '0);
  assign out_status    = status_r;

endmodule

>>> bench/tb_min_tracking_stack.sv
// Self-checking testbench for min_tracking_stack: directed and random push/pop/peek traffic vs. a predictor.
module tb_min_tracking_stack;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH_MAX = mts_pkg::STACK_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic signed [mts_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mts_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    mts_pkg::kind_t                     kind;
    logic signed [mts_pkg::DATA_W-1:0]  value;
    int unsigned                        gap;
  } stack_op_t;

  typedef struct {
    logic signed [mts_pkg::DATA_W-1:0]  top_value;
    logic signed [mts_pkg::DATA_W-1:0]  min_value;
    logic [mts_pkg::DEPTH_W-1:0]        depth;
    logic                               is_empty;
    mts_pkg::status_t                   status;
  } stack_result_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic [mts_pkg::KIND_W-1:0]          in_kind;
  logic signed [mts_pkg::DATA_W-1:0]   in_value;
  logic                                out_valid;
  logic signed [mts_pkg::DATA_W-1:0]   out_top_value;
  logic signed [mts_pkg::DATA_W-1:0]   out_min_value;
  logic [mts_pkg::DEPTH_W-1:0]         out_depth;
  logic                                out_is_empty;
  logic [mts_pkg::STATUS_W-1:0]        out_status;

  stack_op_t                  op_queue[$];
  stack_result_t              pending_results[$];

  logic signed [mts_pkg::DATA_W-1:0]   val_mem[DEPTH_MAX];
  logic signed [mts_pkg::DATA_W-1:0]   min_mem[DEPTH_MAX];
  logic [mts_pkg::DEPTH_W-1:0]         val_cnt;
  logic [mts_pkg::DEPTH_W-1:0]         min_cnt;

  int unsigned                gen_depth;
  bit                         quiet;
  logic                       beat_taken;
  int unsigned                wait_cnt;
  int unsigned                idle_cycles;
  int unsigned                errors;

  min_tracking_stack #(
    .STACK_DEPTH(DEPTH_MAX)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_top_value(out_top_value),
    .out_min_value(out_min_value),
    .out_depth    (out_depth),
    .out_is_empty (out_is_empty),
    .out_status   (out_status)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic stack_result_t predict_stack_op(mts_pkg::kind_t k,
                                                     logic signed [mts_pkg::DATA_W-1:0] v);
    stack_result_t r;
    r.status = mts_pkg::STATUS_OK;
    case (k)
      mts_pkg::KIND_PUSH: begin
        if (val_cnt >= DEPTH_MAX) begin
          r.status = mts_pkg::STATUS_FULL;
        end else begin
          if (min_cnt == 0 || v <= min_mem[min_cnt - 1]) begin
            if (min_cnt < DEPTH_MAX) begin
              min_mem[min_cnt] = v;
              min_cnt++;
            end
          end
          val_mem[val_cnt] = v;
          val_cnt++;
        end
      end
      mts_pkg::KIND_POP: begin
        if (val_cnt == 0) begin
          r.status = mts_pkg::STATUS_EMPTY;
        end else begin
          if (min_cnt > 0 && val_mem[val_cnt - 1] <= min_mem[min_cnt - 1]) min_cnt--;
          val_cnt--;
        end
      end
      default: ;
    endcase
    r.top_value = (val_cnt > 0) ? val_mem[val_cnt - 1] : '0;
    r.min_value = (val_cnt > 0 && min_cnt > 0) ? min_mem[min_cnt - 1] : '0;
    r.depth     = val_cnt;
    r.is_empty  = (val_cnt == 0);
    return r;
  endfunction

  function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3, 4:    return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(mts_pkg::kind_t k, logic signed [mts_pkg::DATA_W-1:0] v);
    stack_op_t op;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    op.kind  = k;
    op.value = v;
    op.gap   = quiet ? 0 : $urandom_range(0, 12);
    op_queue.push_back(op);
    if (k == mts_pkg::KIND_PUSH && gen_depth < DEPTH_MAX) gen_depth++;
    if (k == mts_pkg::KIND_POP && gen_depth > 0) gen_depth--;
  endtask

  task automatic add_random_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) add_op(mts_pkg::KIND_PUSH, pick_value());
    else if (r < push_pct + (100 - push_pct) * 6 / 10) add_op(mts_pkg::KIND_POP, pick_value());
    else if (r < 95) add_op(mts_pkg::KIND_PEEK, pick_value());
    else add_op(mts_pkg::KIND_RSVD, pick_value());
  endtask

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    stack_op_t op;
    if (rst_n) begin
      if (!start || beat_taken) begin
        if (op_queue.size() > 0 && wait_cnt >= op_queue[0].gap) begin
          op = op_queue.pop_front();
          start    <= 1'b1;
          in_kind  <= op.kind;
          in_value <= op.value;
          wait_cnt = 0;
        end else begin
          start <= 1'b0;
          if (op_queue.size() > 0) wait_cnt++;
        end
      end
    end
  end

  // monitor and predictor: sample on the rising edge
  always @(posedge clk) begin
    stack_result_t exp_res;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with no expected result, depth %0d", $time, out_depth);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("top_value", exp_res.top_value, out_top_value);
          check_field("min_value", exp_res.min_value, out_min_value);
          check_field("depth", exp_res.depth, out_depth);
          check_field("is_empty", exp_res.is_empty, out_is_empty);
          check_field("status", exp_res.status, out_status);
        end
      end
      if (start && !busy) begin
        pending_results.push_back(predict_stack_op(mts_pkg::kind_t'(in_kind), in_value));
      end
      beat_taken <= start && !busy;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    start       = 1'b0;
    in_kind     = mts_pkg::KIND_PEEK;
    in_value    = '0;
    rst_n       = 1'b0;
    val_cnt     = '0;
    min_cnt     = '0;
    gen_depth   = 0;
    quiet       = 1'b0;
    wait_cnt    = 0;
    idle_cycles = 0;
    errors      = 0;

    // directed: empty cases, extremes, ties on the minimum, unused kind code
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_PEEK, 32'sd0);
    add_op(mts_pkg::KIND_RSVD, VAL_MIN);
    add_op(mts_pkg::KIND_PUSH, VAL_MAX);
    add_op(mts_pkg::KIND_PUSH, VAL_MAX);
    add_op(mts_pkg::KIND_PUSH, VAL_MIN);
    add_op(mts_pkg::KIND_PUSH, 32'sd0);
    add_op(mts_pkg::KIND_PEEK, -32'sd1);
    add_op(mts_pkg::KIND_RSVD, 32'sd5);
    add_op(mts_pkg::KIND_POP, VAL_MAX);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_PUSH, -32'sd1);
    add_op(mts_pkg::KIND_PUSH, 32'sd5);
    add_op(mts_pkg::KIND_PUSH, -32'sd1);
    add_op(mts_pkg::KIND_PUSH, -32'sd7);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_POP, 32'sd0);
    add_op(mts_pkg::KIND_POP, 32'sd0);

    // shallow random walk
    repeat (400) add_random_op(gen_depth > 24 ? 30 : 45);
    // climb to full, then push against the full stack
    while (gen_depth < DEPTH_MAX) add_random_op(92);
    repeat (25) add_random_op(75);
    // partial drain
    repeat (150) add_random_op(10);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || start) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
